@@ src/kfar_pkg.sv @@
package kfar_pkg;

    localparam int FIFO_DEPTH = 128;
    localparam int KEY_COUNT  = 64;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int MAP_AW     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    localparam logic [15:0] PERIOD_RESET = 16'd75;

    localparam logic [2:0] ACT_DOWN = 3'd0;
    localparam logic [2:0] ACT_UP   = 3'd1;
    localparam logic [2:0] ACT_TICK = 3'd2;
    localparam logic [2:0] ACT_POLL = 3'd3;
    localparam logic [2:0] ACT_READ = 3'd4;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] key_code;
    } in_item_t;

    typedef struct packed {
        logic [7:0] key_out;
        logic       key_valid;
        logic       push_ok;
        logic       repeat_fired;
        logic       not_empty;
        logic       key_pressing;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic mem_rd;
        logic finish;
    } kfar_cmd_t;

    typedef struct packed {
        logic is_read;
        logic out_free;
    } kfar_sts_t;

    function automatic logic [FIFO_AW-1:0] next_slot(input logic [FIFO_AW-1:0] idx);
        if (idx == FIFO_AW'(FIFO_DEPTH - 1))
            return '0;
        else
            return idx + 1'b1;
    endfunction

    function automatic logic key_in_map(input logic [7:0] key);
        return ({1'b0, key} < 9'(KEY_COUNT));
    endfunction

endpackage

@@ src/kfar_ctrl.sv @@
module kfar_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  kfar_pkg::kfar_sts_t sts,
    output kfar_pkg::kfar_cmd_t cmd
);
    import kfar_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.is_read ? S_READ : S_DONE;
            end
            S_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the result register can take the word
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ src/kfar_dp.sv @@
module kfar_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kfar_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output kfar_pkg::out_item_t  out_data,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  kfar_pkg::kfar_cmd_t  cmd,
    output kfar_pkg::kfar_sts_t  sts
);
    import kfar_pkg::*;

    logic [7:0]         mem [FIFO_DEPTH];
    logic [7:0]         rd_data_reg;

    logic [2:0]         act_reg;
    logic [7:0]         key_reg;
    logic [FIFO_AW-1:0] rd_idx_reg;
    logic [FIFO_AW-1:0] wr_idx_reg;
    logic [KEY_COUNT-1:0] map_reg;
    logic               held_reg;
    logic [7:0]         held_key_reg;
    logic [31:0]        deadline_reg;
    logic [31:0]        now_reg;
    logic [15:0]        period_reg;
    logic               fired_reg;
    logic               push_ok_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic               fire;
    logic               push_req;
    logic [7:0]         push_key;
    logic               full;
    logic               map_we;
    logic [7:0]         map_key;
    logic               map_val;
    logic [17:0]        period3;
    logic               pop;
    logic [FIFO_AW-1:0] rd_idx_next;

    assign full    = (next_slot(wr_idx_reg) == rd_idx_reg);
    assign fire    = held_reg && (deadline_reg <= now_reg);
    assign period3 = {2'b00, period_reg} + {1'b0, period_reg, 1'b0};

    assign sts.is_read  = (act_reg == ACT_READ);
    assign sts.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        push_req = 1'b0;
        push_key = key_reg;
        map_we   = 1'b0;
        map_key  = key_reg;
        map_val  = 1'b0;
        if (cmd.exec)
        begin
            case (act_reg)
                ACT_DOWN:
                begin
                    push_req = 1'b1;
                    map_we   = 1'b1;
                    map_val  = 1'b1;
                end
                ACT_UP:
                begin
                    map_we = 1'b1;
                end
                ACT_POLL, ACT_READ:
                begin
                    if (fire)
                    begin
                        push_req = 1'b1;
                        push_key = held_key_reg;
                        map_we   = 1'b1;
                        map_key  = held_key_reg;
                        map_val  = 1'b1;
                    end
                end
                default:
                begin
                    push_req = 1'b0;
                end
            endcase
        end
    end

    // key store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (push_req && !full)
            mem[wr_idx_reg] <= push_key;
        if (cmd.mem_rd)
            rd_data_reg <= mem[rd_idx_reg];
    end

    assign pop         = cmd.finish && (act_reg == ACT_READ) && (rd_idx_reg != wr_idx_reg);
    assign rd_idx_next = pop ? next_slot(rd_idx_reg) : rd_idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= in_data.action;
            key_reg <= in_data.key_code;
        end
        if (cmd.finish)
        begin
            out_data_reg.key_out      <= pop ? rd_data_reg : 8'd0;
            out_data_reg.key_valid    <= pop;
            out_data_reg.push_ok      <= push_ok_reg;
            out_data_reg.repeat_fired <= fired_reg;
            out_data_reg.not_empty    <= (rd_idx_next != wr_idx_reg);
            out_data_reg.key_pressing <= key_in_map(key_reg) && map_reg[key_reg[MAP_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            map_reg       <= '0;
            held_reg      <= 1'b0;
            held_key_reg  <= 8'd0;
            deadline_reg  <= 32'd0;
            now_reg       <= 32'd0;
            period_reg    <= PERIOD_RESET;
            fired_reg     <= 1'b0;
            push_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                period_reg <= cfg_wr_data;

            if (cmd.capture)
            begin
                fired_reg   <= 1'b0;
                push_ok_reg <= 1'b0;
            end

            if (push_req && !full)
                wr_idx_reg <= next_slot(wr_idx_reg);

            if (map_we && key_in_map(map_key))
                map_reg[map_key[MAP_AW-1:0]] <= map_val;

            if (cmd.exec)
            begin
                case (act_reg)
                    ACT_DOWN:
                    begin
                        if (!held_reg)
                        begin
                            held_reg     <= 1'b1;
                            held_key_reg <= key_reg;
                            deadline_reg <= now_reg + {14'd0, period3};
                        end
                        push_ok_reg <= !full;
                    end
                    ACT_UP:
                    begin
                        held_reg <= 1'b0;
                    end
                    ACT_TICK:
                    begin
                        now_reg <= now_reg + 32'd1;
                    end
                    ACT_POLL, ACT_READ:
                    begin
                        // repeat re-arms even when the FIFO drops the key
                        if (fire)
                        begin
                            fired_reg    <= 1'b1;
                            deadline_reg <= now_reg + {16'd0, period_reg};
                        end
                    end
                    default:
                    begin
                        fired_reg <= 1'b0;
                    end
                endcase
            end

            rd_idx_reg <= rd_idx_next;

            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result written over an unaccepted word");

    a_push_ok_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && act_reg == ACT_DOWN) |=>
            (push_ok_reg == (wr_idx_reg != $past(wr_idx_reg))))
        else $error("push_ok disagrees with write index movement");

    a_pop_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && act_reg != ACT_READ) |=> $stable(rd_idx_reg))
        else $error("read index moved on a non-read word");

    a_never_full_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (push_req && full) |=> $stable(wr_idx_reg))
        else $error("write index moved while FIFO full");

endmodule

@@ src/key_event_fifo_with_auto_repeat.sv @@
// Key event FIFO with typematic auto-repeat.
// Input channel in_valid/in_ready carries one word {action, key_code}:
// key down, key up, tick, poll, or read oldest key. Every input word gives
// exactly one result word on out_valid/out_ready.
// After acceptance the controller steps through exec, read (reads only: the
// key store has a registered read port, read after the repeat step's push)
// and done, which loads the output register; it handles one word at a time.
// The next word is accepted while a finished result still waits in the
// output register; if the receiver stalls further, the block holds the next
// result in its final state and stops accepting until the register frees.
// The user must write the repeat period register via cfg_wr_en/cfg_wr_data
// only while idle; the block itself does not enforce this.
// Reset (rst_n, asynchronous) empties the FIFO, clears the key map, held key,
// time and deadline, and sets the repeat period to 75 ticks. No clearing
// pass is needed; the block accepts input right after reset.
module key_event_fifo_with_auto_repeat (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  kfar_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output kfar_pkg::out_item_t out_data,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data
);
    import kfar_pkg::*;

    kfar_cmd_t cmd;
    kfar_sts_t sts;

    kfar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kfar_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
